>>> hw/rtl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 hash engine.
package sha256_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int LEN_POS     = 56;
  localparam int NUM_ROUNDS  = 64;
  localparam int NUM_WORDS   = 8;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_LAST = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;
  } out_word_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_LAST,
    KIND_END
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data_byte;
  } q_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROUND,
    BK_ADD,
    BK_PAD,
    BK_OUT
  } back_st_t;

  localparam logic [31:0] IV_TAB [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch_fn(input logic [31:0] e, input logic [31:0] f,
                                        input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_fn(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

>>> hw/rtl/sha256_front.sv
// Input stage: accept words, decode the action and hand items to the queue.
module sha256_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha256_pkg::in_word_t in_word,
  input  logic                q_full,
  output logic                q_push,
  output sha256_pkg::q_item_t q_item
);
  import sha256_pkg::*;

  logic    front_valid_r, front_valid_nxt;
  q_item_t front_item_r, front_item_nxt;
  logic    accept;
  logic    keep;
  q_item_t dec_item;

  assign in_stall = front_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = front_valid_r && !q_full;
  assign q_item   = front_item_r;

  always_comb begin
    dec_item.data_byte = in_word.data_byte;
    dec_item.kind      = KIND_BYTE;
    keep               = 1'b1;
    unique case (in_word.action)
      ACT_BYTE: dec_item.kind = KIND_BYTE;
      ACT_LAST: dec_item.kind = KIND_LAST;
      ACT_END:  dec_item.kind = KIND_END;
      default:  keep = 1'b0;
    endcase
  end

  always_comb begin
    front_valid_nxt = front_valid_r;
    front_item_nxt  = front_item_r;
    if (q_push) begin
      front_valid_nxt = 1'b0;
    end
    if (accept) begin
      front_valid_nxt = keep;
      front_item_nxt  = dec_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
    front_item_r <= front_item_nxt;
  end

endmodule

>>> hw/rtl/sha256_queue.sv
// Short item queue between the input stage and the hash core.
module sha256_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sha256_pkg::q_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output sha256_pkg::q_item_t q_item
);
  import sha256_pkg::*;

  q_item_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = cnt_r == Q_CW'(Q_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/sha256_back.sv
// Hash core: block fill, padding, 64-round compression and digest output.
module sha256_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  sha256_pkg::q_item_t   q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_word_t out_word
);
  import sha256_pkg::*;

  back_st_t    st_r, st_nxt;
  logic [31:0] chain_r [NUM_WORDS];
  logic [31:0] chain_nxt [NUM_WORDS];
  logic [31:0] vars_r [NUM_WORDS];
  logic [31:0] vars_nxt [NUM_WORDS];
  logic [511:0] win_r, win_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        fin_r, fin_nxt;
  logic        first_r, first_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        len_done_r, len_done_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic        take;
  logic        wr_byte;
  logic        pos_end;
  logic        out_load;
  logic [7:0]  pad_byte;
  logic [7:0]  byte_in;
  logic [5:0]  pos_after;
  logic [31:0] w_cur;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign take     = (st_r == BK_IDLE) && q_valid;
  assign q_pop    = take;
  assign wr_byte  = (take && q_item.kind != KIND_END) || (st_r == BK_PAD);
  assign pos_end  = pos_r == 6'(BLOCK_BYTES - 1);
  assign out_load = (st_r == BK_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign pad_byte = first_r ? PAD_MARK :
                    (len_ok_r && pos_r >= 6'(LEN_POS)) ?
                    bits_r[{~pos_r[2:0], 3'b000} +: 8] : 8'h00;
  assign byte_in   = (st_r == BK_PAD) ? pad_byte : q_item.data_byte;
  assign pos_after = (q_item.kind == KIND_LAST) ? pos_r + 1'b1 : pos_r;

  assign w_cur = win_r[511:480];
  assign w_new = sml_sig1(win_r[63:32]) + win_r[223:192] + sml_sig0(win_r[479:448]) + w_cur;
  assign t1    = vars_r[7] + big_sig1(vars_r[4]) + ch_fn(vars_r[4], vars_r[5], vars_r[6]) +
                 K_TAB[rnd_r] + w_cur;
  assign t2    = big_sig0(vars_r[0]) + maj_fn(vars_r[0], vars_r[1], vars_r[2]);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (take) begin
          if (wr_byte && pos_end) begin
            st_nxt = BK_ROUND;
          end else if (q_item.kind != KIND_BYTE) begin
            st_nxt = BK_PAD;
          end
        end
      end
      BK_ROUND: begin
        if (rnd_r == 6'(NUM_ROUNDS - 1)) begin
          st_nxt = BK_ADD;
        end
      end
      BK_ADD: begin
        if (!fin_r) begin
          st_nxt = BK_IDLE;
        end else if (len_done_r) begin
          st_nxt = BK_OUT;
        end else begin
          st_nxt = BK_PAD;
        end
      end
      BK_PAD: begin
        if (pos_end) begin
          st_nxt = BK_ROUND;
        end
      end
      BK_OUT: begin
        if (out_load && oidx_r == 3'(NUM_WORDS - 1)) begin
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    chain_nxt     = chain_r;
    vars_nxt      = vars_r;
    win_nxt       = win_r;
    bits_nxt      = bits_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    oidx_nxt      = oidx_r;
    fin_nxt       = fin_r;
    first_nxt     = first_r;
    len_ok_nxt    = len_ok_r;
    len_done_nxt  = len_done_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (wr_byte) begin
      win_nxt = {win_r[503:0], byte_in};
      pos_nxt = pos_r + 1'b1;
      if (pos_end) begin
        vars_nxt = chain_r;
        rnd_nxt  = '0;
      end
    end

    if (take) begin
      if (q_item.kind != KIND_END) begin
        bits_nxt = bits_r + 64'd8;
      end
      if (q_item.kind != KIND_BYTE) begin
        fin_nxt      = 1'b1;
        first_nxt    = 1'b1;
        len_ok_nxt   = pos_after < 6'(LEN_POS);
        len_done_nxt = 1'b0;
      end
    end

    if (st_r == BK_PAD) begin
      first_nxt = 1'b0;
      if (pos_end) begin
        if (len_ok_r) begin
          len_done_nxt = 1'b1;
        end else begin
          len_ok_nxt = 1'b1;
        end
      end
    end

    if (st_r == BK_ROUND) begin
      win_nxt     = {win_r[479:0], w_new};
      rnd_nxt     = rnd_r + 1'b1;
      vars_nxt[7] = vars_r[6];
      vars_nxt[6] = vars_r[5];
      vars_nxt[5] = vars_r[4];
      vars_nxt[4] = vars_r[3] + t1;
      vars_nxt[3] = vars_r[2];
      vars_nxt[2] = vars_r[1];
      vars_nxt[1] = vars_r[0];
      vars_nxt[0] = t1 + t2;
    end

    if (st_r == BK_ADD) begin
      for (int j = 0; j < NUM_WORDS; j++) begin
        chain_nxt[j] = chain_r[j] + vars_r[j];
      end
      oidx_nxt = '0;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.word_index  = oidx_r;
      out_word_nxt.digest_word = chain_r[oidx_r];
      out_word_nxt.last_word   = oidx_r == 3'(NUM_WORDS - 1);
      oidx_nxt                 = oidx_r + 1'b1;
      if (oidx_r == 3'(NUM_WORDS - 1)) begin
        chain_nxt = IV_TAB;
        bits_nxt  = '0;
        fin_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      chain_r     <= IV_TAB;
      bits_r      <= '0;
      pos_r       <= '0;
      rnd_r       <= '0;
      oidx_r      <= '0;
      fin_r       <= 1'b0;
      first_r     <= 1'b0;
      len_ok_r    <= 1'b0;
      len_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      chain_r     <= chain_nxt;
      bits_r      <= bits_nxt;
      pos_r       <= pos_nxt;
      rnd_r       <= rnd_nxt;
      oidx_r      <= oidx_nxt;
      fin_r       <= fin_nxt;
      first_r     <= first_nxt;
      len_ok_r    <= len_ok_nxt;
      len_done_r  <= len_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    vars_r     <= vars_nxt;
    win_r      <= win_nxt;
    out_word_r <= out_word_nxt;
  end

  a_out_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_OUT) |-> (fin_r && len_done_r))
    else $error("digest output without a finished length block");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_IDLE) |-> !fin_r)
    else $error("idle with a message end still pending");

  a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_ADD) |-> ($past(st_r) == BK_ROUND && $past(rnd_r) == 6'(NUM_ROUNDS - 1)))
    else $error("chain update not preceded by the final round");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.last_word) |-> (out_word_r.word_index == 3'(NUM_WORDS - 1)))
    else $error("last word flag on a word other than the eighth");

endmodule

>>> hw/rtl/sha256_hash_engine_unit.sv
// Top level of the SHA-256 hash engine: input stage, item queue and hash core.
//
//   channel   ports                          carries
//   input     in_valid / in_stall / in_word  action, data_byte
//   result    out_valid / out_stall / out_word  word_index, digest_word, last_word
//
// A byte passes the input register and the queue into the core; every 64th byte
// starts the rounds and a chain update in the shared round unit, while the core
// takes no new bytes and the queue buffers them.
// Message end adds padding at one byte per cycle (up to 64, or 72 with an extra
// block), one or two compressions, then eight digest words, one per cycle unless
// stalled. Reset is synchronous on rst_n low, with no clearing pass.
// A stalled result waits in the output register; the queue takes bytes until full.
module sha256_hash_engine_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha256_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_word_t out_word
);
  import sha256_pkg::*;

  logic    q_full;
  logic    q_push;
  q_item_t push_item;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_item;

  sha256_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  sha256_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  sha256_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of sha256_hash_engine_unit with its own SHA-256 digest predictor.
module testbench;
  import sha256_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STIM_ITEMS = 460;
  localparam int TAIL_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  in_word_t  byte_q [$];
  out_word_t digest_q [$];
  int        stim_total = 0;
  int        sent_cnt = 0;
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  out_word_t want;

  logic [31:0] chain_st [8];
  logic [7:0]  blk_buf [64];
  logic [63:0] bit_count;

  sha256_hash_engine_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_blk();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wt, s0, s1, x2, x15;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    a = chain_st[0]; b = chain_st[1]; c = chain_st[2]; d = chain_st[3];
    e = chain_st[4]; f = chain_st[5]; g = chain_st[6]; h = chain_st[7];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        x2 = w[(t - 2) & 15];
        x15 = w[(t - 15) & 15];
        s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        wt = s1 + w[(t - 7) & 15] + s0 + w[t & 15];
        w[t & 15] = wt;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[t] + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_st[0] += a; chain_st[1] += b; chain_st[2] += c; chain_st[3] += d;
    chain_st[4] += e; chain_st[5] += f; chain_st[6] += g; chain_st[7] += h;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    int pos;
    pos = int'(bit_count[8:3]);
    blk_buf[pos] = v;
    bit_count += 64'd8;
    if (pos == 63) compress_blk();
  endfunction

  function automatic void close_message();
    int pos;
    out_word_t w;
    pos = int'(bit_count[8:3]);
    blk_buf[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      compress_blk();
      pos = 0;
    end
    while (pos < 56) begin
      blk_buf[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) blk_buf[56 + i] = bit_count[63 - 8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      w.word_index = 3'(i);
      w.digest_word = chain_st[i];
      w.last_word = (i == 7);
      digest_q.push_back(w);
    end
    chain_st = HASH_INIT;
    bit_count = '0;
  endfunction

  function automatic void hash_item(input in_word_t it);
    case (it.action)
      ACT_BYTE: absorb_byte(it.data_byte);
      ACT_LAST: begin
        absorb_byte(it.data_byte);
        close_message();
      end
      ACT_END: close_message();
      default: ;
    endcase
  endfunction

  function automatic void push_word(input logic [1:0] act, input logic [7:0] v);
    in_word_t it;
    it.action = act;
    it.data_byte = v;
    byte_q.push_back(it);
    stim_total++;
  endfunction

  function automatic void push_message(input int len, input bit end_on_last);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) push_word(ACT_UNUSED, 8'($urandom_range(255)));
      if (end_on_last && i == len - 1) push_word(ACT_LAST, 8'($urandom_range(255)));
      else push_word(ACT_BYTE, 8'($urandom_range(255)));
    end
    if (!end_on_last || len == 0) push_word(ACT_END, 8'($urandom_range(255)));
  endfunction

  function automatic int idle_pct(input bit sender);
    if (sent_cnt < stim_total / 3) return sender ? 38 : 50;
    if (sent_cnt < 2 * stim_total / 3) return sender ? 50 : 38;
    return 0;
  endfunction

  task automatic note_fail(input string what, input out_word_t exp_w, input out_word_t got_w);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("%s: expected idx=%0d word=%08h last=%0b, got idx=%0d word=%08h last=%0b",
               what, exp_w.word_index, exp_w.digest_word, exp_w.last_word,
               got_w.word_index, got_w.digest_word, got_w.last_word);
  endtask

  // drive input words, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hash_item(in_word);
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_valid <= 1'b1;
          in_word <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // check digest words, randomize stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          note_fail("unexpected digest word", '0, out_word);
        end else begin
          want = digest_q.pop_front();
          if (want.word_index !== out_word.word_index ||
              want.digest_word !== out_word.digest_word ||
              want.last_word !== out_word.last_word)
            note_fail("digest mismatch", want, out_word);
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("sha256_hash_engine_unit verification failed");
      $finish;
    end
  end

  initial begin
    int len;
    int pick;
    int boundary [12];
    chain_st = HASH_INIT;
    bit_count = '0;
    boundary = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

    push_word(ACT_END, 8'h00);
    push_word(ACT_LAST, 8'h00);
    push_word(ACT_LAST, 8'hff);
    push_word(ACT_BYTE, 8'hff);
    push_word(ACT_UNUSED, 8'h5a);
    push_word(ACT_BYTE, 8'h00);
    push_word(ACT_END, 8'hff);
    push_word(ACT_BYTE, 8'h61);
    push_word(ACT_BYTE, 8'h62);
    push_word(ACT_LAST, 8'h63);
    push_word(ACT_UNUSED, 8'ha5);
    push_word(ACT_END, 8'h00);

    while (stim_total < STIM_ITEMS) begin
      pick = $urandom_range(9);
      if (pick < 4) len = $urandom_range(20);
      else if (pick < 7) len = boundary[$urandom_range(11)];
      else if (pick < 9) len = $urandom_range(70, 21);
      else len = $urandom_range(140, 100);
      if (len > STIM_ITEMS - stim_total) len = STIM_ITEMS - stim_total;
      push_message(len, 1'($urandom_range(1)));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    fail_cnt += digest_q.size();

    if (fail_cnt == 0) begin
      $display("sha256_hash_engine_unit verification clean");
    end else begin
      $display("sha256_hash_engine_unit verification failed");
    end
    $finish;
  end

endmodule
